// File: rtl/eptc_pkg.sv
// Shared types, constants and calendar helpers for the epoch-to-UTC converter.
package eptc_pkg;

  // Default width of the seconds count.
  localparam int unsigned SecondsWidthDef = 38;

  // Widest seconds count the day split supports.
  localparam int unsigned SecondsWidthMax = 48;

  // Width of one operand of the shared divide unit.
  localparam int unsigned OperandWidth = 32;

  // A day of 86400 seconds is 675 << 7. The shifted count is split into a
  // high part and a low chunk of DayChunk bits so each division stays within
  // one operand; a remainder of 675 fits in DayRemWidth bits.
  localparam int unsigned DayShift    = 7;
  localparam int unsigned DayChunk    = 21;
  localparam int unsigned DayRemWidth = 10;

  // Width that holds the largest divisor used by the converter.
  localparam int unsigned DivisorWidth = 18;

  localparam logic [DivisorWidth-1:0] SecondsPerDayOdd = 18'd675;
  localparam logic [DivisorWidth-1:0] SecondsPerHour   = 18'd3600;
  localparam logic [DivisorWidth-1:0] SecondsPerMin    = 18'd60;
  localparam logic [DivisorWidth-1:0] DaysPerWeek      = 18'd7;
  localparam logic [DivisorWidth-1:0] Days400Y         = 18'((400 * 365) + 97);
  localparam logic [DivisorWidth-1:0] Days100Y         = 18'((100 * 365) + 24);
  localparam logic [DivisorWidth-1:0] Days4Y           = 18'((4 * 365) + 1);
  localparam logic [DivisorWidth-1:0] DaysPerYear      = 18'd365;

  // Reciprocals scaled by 2^32 and rounded down; the estimate they give is
  // at most one below the true quotient for any operand below 2^32.
  localparam longint unsigned RecipScale = 64'h1_0000_0000;
  localparam logic [OperandWidth-1:0] RecipDayOdd =
    OperandWidth'(RecipScale / 64'(SecondsPerDayOdd));
  localparam logic [OperandWidth-1:0] RecipHour = OperandWidth'(RecipScale / 64'(SecondsPerHour));
  localparam logic [OperandWidth-1:0] RecipMin  = OperandWidth'(RecipScale / 64'(SecondsPerMin));
  localparam logic [OperandWidth-1:0] RecipWeek = OperandWidth'(RecipScale / 64'(DaysPerWeek));
  localparam logic [OperandWidth-1:0] Recip400Y = OperandWidth'(RecipScale / 64'(Days400Y));
  localparam logic [OperandWidth-1:0] Recip100Y = OperandWidth'(RecipScale / 64'(Days100Y));
  localparam logic [OperandWidth-1:0] Recip4Y   = OperandWidth'(RecipScale / 64'(Days4Y));
  localparam logic [OperandWidth-1:0] RecipYear = OperandWidth'(RecipScale / 64'(DaysPerYear));

  // Days from 1601-01-01 to 1970-01-01; 1601 opens a 400-year cycle.
  localparam logic [DivisorWidth-1:0] DaysFrom1601 = 18'd134774;

  // 1970-01-01 was a Thursday.
  localparam logic [2:0] EpochWeekday = 3'd4;

  // The year accumulator holds (year - 1900) modulo 2^14. Year 1601 is its
  // origin, so it starts at 1601 - 1900 = -299.
  localparam logic [13:0] YearBiasInit = 14'(16384 - 299);

  // Months are numbered from zero, so the last month is December.
  localparam logic [3:0] MonthDec = 4'd11;
  localparam logic [3:0] MonthFeb = 4'd1;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LAUNCH = 5'b00010,
    ST_WAIT   = 5'b00100,
    ST_MONTH  = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_e;

  // Divisions run by the shared divide unit, in the order they are issued.
  typedef enum logic [3:0] {
    OP_DAYH = 4'd0,
    OP_DAYL = 4'd1,
    OP_HOUR = 4'd2,
    OP_MIN  = 4'd3,
    OP_WDAY = 4'd4,
    OP_C400 = 4'd5,
    OP_C100 = 4'd6,
    OP_C4   = 4'd7,
    OP_C1   = 4'd8
  } op_e;

  function automatic logic [DivisorWidth-1:0] op_divisor(input op_e op);
    logic [DivisorWidth-1:0] d;
    case (op)
      OP_DAYH: d = SecondsPerDayOdd;
      OP_DAYL: d = SecondsPerDayOdd;
      OP_HOUR: d = SecondsPerHour;
      OP_MIN:  d = SecondsPerMin;
      OP_WDAY: d = DaysPerWeek;
      OP_C400: d = Days400Y;
      OP_C100: d = Days100Y;
      OP_C4:   d = Days4Y;
      OP_C1:   d = DaysPerYear;
      default: d = DaysPerYear;
    endcase
    return d;
  endfunction

  function automatic logic [OperandWidth-1:0] op_recip(input op_e op);
    logic [OperandWidth-1:0] m;
    case (op)
      OP_DAYH: m = RecipDayOdd;
      OP_DAYL: m = RecipDayOdd;
      OP_HOUR: m = RecipHour;
      OP_MIN:  m = RecipMin;
      OP_WDAY: m = RecipWeek;
      OP_C400: m = Recip400Y;
      OP_C100: m = Recip100Y;
      OP_C4:   m = Recip4Y;
      OP_C1:   m = RecipYear;
      default: m = RecipYear;
    endcase
    return m;
  endfunction

  // Length of a month, with February stretched in leap years.
  function automatic logic [4:0] month_span(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/epoch_seconds_to_utc_calendar.sv
// Top level of the epoch-seconds to UTC calendar converter.
//
// Usage: raise start_i with a seconds count on epoch_seconds_i; the beat is
// taken at the rising edge where start_i is high and busy_o is low. busy_o
// then stays high until the result has been shown. The result appears on
// the output ports for exactly one cycle, marked by done_o, and must be
// captured in that cycle: the receiver has no way to hold it off.
//
// Sequence: nine divisions by constants run one after another on a shared
// unit that multiplies by a reciprocal, multiplies back and corrects once.
// Each division passes through launch, estimate, back-multiply, correction
// and hand-back. A month walk then follows, and a final state shows the
// result. The next beat is accepted only once the result has been shown,
// so conversions do not overlap; only the month walk varies in length.
//
// Reset returns the sequencer to idle and drops any conversion in flight;
// the block carries no other state from one beat into the next.
module epoch_seconds_to_utc_calendar #(
  parameter int unsigned SECONDS_WIDTH = eptc_pkg::SecondsWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [SECONDS_WIDTH-1:0] epoch_seconds_i,
  output logic                     done_o,
  output logic [5:0]               second_of_minute_o,
  output logic [5:0]               minute_of_hour_o,
  output logic [4:0]               hour_of_day_o,
  output logic [2:0]               weekday_o,
  output logic [13:0]              years_since_1900_o,
  output logic [3:0]               month_index_o,
  output logic [4:0]               day_of_month_o,
  output logic [8:0]               day_of_year_o
);
  import eptc_pkg::*;

  state_e state_q, state_d;
  op_e    op_q, op_d;

  // Working registers; the calendar fields double as the output registers.
  logic [SecondsWidthMax-1:0] secs_q, secs_d;
  logic [OperandWidth-1:0]    work_q, work_d;
  logic [OperandWidth-1:0]    days_q, days_d;
  logic [5:0]   sec_q, sec_d;
  logic [5:0]   min_q, min_d;
  logic [4:0]   hour_q, hour_d;
  logic [2:0]   wday_q, wday_d;
  logic [13:0]  year_q, year_d;
  logic [1:0]   q100_q, q100_d;
  logic [4:0]   q4_q, q4_d;
  logic         leap_q, leap_d;
  logic [3:0]   mon_q, mon_d;
  logic [8:0]   mday_q, mday_d;
  logic [8:0]   yday_q, yday_d;

  // Shared divide unit connection.
  logic                    div_start;
  logic [OperandWidth-1:0] div_dividend;
  logic [OperandWidth-1:0] div_divisor;
  logic                    div_done;
  logic [OperandWidth-1:0] div_quo;
  logic [OperandWidth-1:0] div_rem;

  // Quotient clamp for the century and single-year steps. The quotient can
  // reach four only on the last day of a 400-year or 4-year span; that day
  // then belongs to the fourth block, so the divisor goes back into the
  // remainder.
  logic                    clamp;
  logic [OperandWidth-1:0] rem_fixed;
  logic [1:0]              q_small;
  logic [8:0]              yday_new;
  logic [4:0]              cur_len;

  assign clamp     = (div_quo > OperandWidth'(3));
  assign rem_fixed = clamp ? (div_rem + div_divisor) : div_rem;
  assign q_small   = clamp ? 2'd3 : div_quo[1:0];
  assign yday_new  = rem_fixed[8:0] + 9'd1;
  assign cur_len   = month_span(mon_q, leap_q);

  // The day count comes from two divisions by 675 of the count shifted down
  // by seven: the high part first, then its remainder joined to the low chunk.
  always_comb begin
    case (op_q)
      OP_DAYH: div_dividend = OperandWidth'(secs_q[SecondsWidthMax-1:DayShift+DayChunk]);
      OP_DAYL: div_dividend = {1'b0, work_q[DayRemWidth-1:0],
                               secs_q[DayShift+DayChunk-1:DayShift]};
      OP_HOUR: div_dividend = OperandWidth'({work_q[DayRemWidth-1:0], secs_q[DayShift-1:0]});
      OP_WDAY: div_dividend = days_q + OperandWidth'(EpochWeekday);
      OP_C400: div_dividend = days_q + OperandWidth'(DaysFrom1601);
      default: div_dividend = work_q;
    endcase
  end

  assign div_divisor = OperandWidth'(op_divisor(op_q));
  assign div_start   = (state_q == ST_LAUNCH);

  eptc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .op_i        (op_q),
    .dividend_i  (div_dividend),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    secs_d  = secs_q;
    work_d  = work_q;
    days_d  = days_q;
    sec_d   = sec_q;
    min_d   = min_q;
    hour_d  = hour_q;
    wday_d  = wday_q;
    year_d  = year_q;
    q100_d  = q100_q;
    q4_d    = q4_q;
    leap_d  = leap_q;
    mon_d   = mon_q;
    mday_d  = mday_q;
    yday_d  = yday_q;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          secs_d  = SecondsWidthMax'(epoch_seconds_i);
          year_d  = YearBiasInit;
          op_d    = OP_DAYH;
          state_d = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          op_d    = op_e'(op_q + 4'd1);
          state_d = ST_LAUNCH;
          case (op_q)
            OP_DAYH: begin
              days_d = {div_quo[OperandWidth-DayChunk-1:0], {DayChunk{1'b0}}};
              work_d = div_rem;
            end
            OP_DAYL: begin
              days_d = {days_q[OperandWidth-1:DayChunk], div_quo[DayChunk-1:0]};
              work_d = div_rem;
            end
            OP_HOUR: begin
              hour_d = div_quo[4:0];
              work_d = div_rem;
            end
            OP_MIN: begin
              min_d = div_quo[5:0];
              sec_d = div_rem[5:0];
            end
            OP_WDAY: begin
              wday_d = div_rem[2:0];
            end
            OP_C400: begin
              year_d = year_q + div_quo[13:0] * 14'd400;
              work_d = div_rem;
            end
            OP_C100: begin
              q100_d = q_small;
              year_d = year_q + {12'd0, q_small} * 14'd100;
              work_d = rem_fixed;
            end
            OP_C4: begin
              q4_d   = div_quo[4:0];
              year_d = year_q + {div_quo[11:0], 2'b00};
              work_d = div_rem;
            end
            OP_C1: begin
              // Year is 1601 + 4k + q1, so it is a multiple of four when q1
              // is three. It is then a century when it is the last year of
              // a century block, and a leap century only in the last one.
              year_d  = year_q + {12'd0, q_small};
              yday_d  = yday_new;
              mday_d  = yday_new;
              mon_d   = '0;
              leap_d  = (q_small == 2'd3) && ((q4_q != 5'd24) || (q100_q == 2'd3));
              op_d    = OP_DAYH;
              state_d = ST_MONTH;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_MONTH: begin
        // Walk the months one a cycle until the day fits.
        if ((mon_q == MonthDec) || (mday_q <= {4'd0, cur_len})) begin
          state_d = ST_EMIT;
        end else begin
          mday_d = mday_q - {4'd0, cur_len};
          mon_d  = mon_q + 4'd1;
        end
      end
      ST_EMIT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_DAYH;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    secs_q <= secs_d;
    work_q <= work_d;
    days_q <= days_d;
    sec_q  <= sec_d;
    min_q  <= min_d;
    hour_q <= hour_d;
    wday_q <= wday_d;
    year_q <= year_d;
    q100_q <= q100_d;
    q4_q   <= q4_d;
    leap_q <= leap_d;
    mon_q  <= mon_d;
    mday_q <= mday_d;
    yday_q <= yday_d;
  end

  assign busy_o             = (state_q != ST_IDLE);
  assign done_o             = (state_q == ST_EMIT);
  assign second_of_minute_o = sec_q;
  assign minute_of_hour_o   = min_q;
  assign hour_of_day_o      = hour_q;
  assign weekday_o          = wday_q;
  assign years_since_1900_o = year_q;
  assign month_index_o      = mon_q;
  assign day_of_month_o     = mday_q[4:0];
  assign day_of_year_o      = yday_q;

endmodule

// File: rtl/eptc_div.sv
// Constant divider built on one shared multiplier: estimate, back-multiply, correct.
module eptc_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  eptc_pkg::op_e                     op_i,
  input  logic [eptc_pkg::OperandWidth-1:0] dividend_i,
  output logic                              done_o,
  output logic [eptc_pkg::OperandWidth-1:0] quotient_o,
  output logic [eptc_pkg::OperandWidth-1:0] remainder_o
);
  import eptc_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_EST  = 4'b0010,
    PH_REM  = 4'b0100,
    PH_FIX  = 4'b1000
  } phase_e;

  phase_e                    phase_q, phase_d;
  logic [OperandWidth-1:0]   x_q, x_d;
  logic [OperandWidth-1:0]   quo_q, quo_d;
  logic [OperandWidth-1:0]   rem_q, rem_d;
  logic [DivisorWidth-1:0]   div_q, div_d;
  logic [OperandWidth-1:0]   recip_q, recip_d;
  logic                      done_q, done_d;
  logic [OperandWidth-1:0]   mul_a;
  logic [OperandWidth-1:0]   mul_b;
  logic [2*OperandWidth-1:0] product;

  // The multiplier first forms the quotient estimate, then the product of
  // that estimate and the divisor.
  assign mul_a   = (phase_q == PH_EST) ? x_q : quo_q;
  assign mul_b   = (phase_q == PH_EST) ? recip_q : OperandWidth'(div_q);
  assign product = mul_a * mul_b;

  always_comb begin
    phase_d = phase_q;
    x_d     = x_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    div_d   = div_q;
    recip_d = recip_q;
    done_d  = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          x_d     = dividend_i;
          div_d   = op_divisor(op_i);
          recip_d = op_recip(op_i);
          phase_d = PH_EST;
        end
      end
      PH_EST: begin
        quo_d   = product[2*OperandWidth-1:OperandWidth];
        phase_d = PH_REM;
      end
      PH_REM: begin
        rem_d   = x_q - product[OperandWidth-1:0];
        phase_d = PH_FIX;
      end
      PH_FIX: begin
        // The estimate is at most one short.
        if (rem_q >= OperandWidth'(div_q)) begin
          quo_d = quo_q + OperandWidth'(1);
          rem_d = rem_q - OperandWidth'(div_q);
        end
        done_d  = 1'b1;
        phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    div_q   <= div_d;
    recip_q <= recip_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// File: rtl/eptc_checker.sv
// Port-level checker for the epoch-to-UTC converter, bound to the top level.
module eptc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [5:0]  second_of_minute_o,
  input logic [5:0]  minute_of_hour_o,
  input logic [4:0]  hour_of_day_o,
  input logic [2:0]  weekday_o,
  input logic [3:0]  month_index_o,
  input logic [4:0]  day_of_month_o,
  input logic [8:0]  day_of_year_o
);

  // A result beat only comes out of a conversion in flight.
  a_done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("result beat without a conversion in flight");

  // After its result the block is free again.
  a_idle_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o && !done_o)
    else $error("block still busy after its result beat");

  // An accepted beat keeps the block busy and gives no instant result.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("accepted beat did not start a conversion");

  // The time of day and weekday are in range.
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (second_of_minute_o < 6'd60) && (minute_of_hour_o < 6'd60) &&
               (hour_of_day_o < 5'd24) && (weekday_o < 3'd7))
    else $error("time of day or weekday out of range");

  // The date fields are in range.
  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (month_index_o < 4'd12) && (day_of_month_o != 5'd0) &&
               (day_of_year_o != 9'd0) && (day_of_year_o < 9'd367))
    else $error("date field out of range");

endmodule

bind epoch_seconds_to_utc_calendar eptc_checker u_eptc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .start_i            (start_i),
  .busy_o             (busy_o),
  .done_o             (done_o),
  .second_of_minute_o (second_of_minute_o),
  .minute_of_hour_o   (minute_of_hour_o),
  .hour_of_day_o      (hour_of_day_o),
  .weekday_o          (weekday_o),
  .month_index_o      (month_index_o),
  .day_of_month_o     (day_of_month_o),
  .day_of_year_o      (day_of_year_o)
);
